// ===== rtl/sliding_mode_heater_controller_macros.svh =====
// Assertion macros for the sliding-mode heater controller.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef SLIDING_MODE_HEATER_CONTROLLER_MACROS_SVH
`define SLIDING_MODE_HEATER_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define SMHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMHC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SMHC_ASSERT(label, prop, msg)
`define SMHC_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/smhc_pkg.sv =====
// Shared types and constants for the sliding-mode heater controller.
// No dependencies; used by the register-write interface, the serial units and the top level.
package smhc_pkg;

  localparam int DIV_W  = 48;
  localparam int QUO_W  = 28;
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int CNT_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA_HEAT = 3'd0,
    REG_LAMBDA_COOL = 3'd1,
    REG_ALPHA       = 3'd2,
    REG_SWITCH_GAIN = 3'd3,
    REG_COOL_FACTOR = 3'd4,
    REG_BOUNDARY    = 3'd5,
    REG_DUTY_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic [CNT_W-1:0] bits;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/smhc_if.sv =====
// Handshake channels of the controller: samples in, duty results out, register writes.
// Depends on smhc_pkg.
interface smhc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         chan;
  logic [31:0]        time_ms;
  logic signed [15:0] measured_temp;
  logic signed [15:0] setpoint_temp;
  modport source (output valid, chan, time_ms, measured_temp, setpoint_temp, input ready);
  modport sink (input valid, chan, time_ms, measured_temp, setpoint_temp, output ready);
endinterface

interface smhc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_chan;
  logic [14:0] duty;
  logic        first_sample;
  modport source (output valid, out_chan, duty, first_sample, input ready);
  modport sink (input valid, out_chan, duty, first_sample, output ready);
endinterface

interface smhc_cfg_if import smhc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/smhc_div.sv =====
// Restoring divider producing one quotient bit per cycle, shared by all divisions.
// Depends on smhc_pkg; the divisor arrives already shifted to the top quotient bit.
module smhc_div import smhc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   diff;

  assign diff = {1'b0, rem} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.bits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], ~diff[DIV_W]};
      den <= den >> 1;
    end
  end

  assign rsp = '{busy: busy, done: done, quo: quo};

endmodule

// ===== rtl/smhc_mul.sv =====
// Shift-and-add multiplier taking one multiplier bit per cycle.
// Depends on smhc_pkg for its operand widths and handshake structs.
module smhc_mul import smhc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MUL_P_W-1:0] acc;
  logic [MUL_P_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      a_sh <= MUL_P_W'(req.a);
      b_sh <= req.b;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign rsp = '{busy: busy, done: done, prod: acc};

endmodule

// ===== rtl/sliding_mode_heater_controller.sv =====
// Sliding-mode heater controller, top level: registers, channel state and sequencer.
// A channel's first sample, or a sample for an absent channel, goes from the transfer through S_DONE
// to the output register; a full control step is set by the bit-serial divider (up to
// three divisions, of up to 28 quotient bits each) and the serial multiplier.
// One sample is worked on at a time. Reset is synchronous: it clears all channel state and
// loads the register defaults.
`include "sliding_mode_heater_controller_macros.svh"
module sliding_mode_heater_controller import smhc_pkg::*; #(
  parameter int NUM_CHANNELS    = 4,
  parameter int DEFAULT_STEP_MS = 100,
  parameter int MAX_STEP_MS     = 1000
) (
  input logic        clk,
  input logic        rst,
  smhc_in_if.sink    samples,
  smhc_out_if.source results,
  smhc_cfg_if.sink   cfg
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ED   = 10'b0000000010,
    S_LAM  = 10'b0000000100,
    S_SURF = 10'b0000001000,
    S_SAT  = 10'b0000010000,
    S_PD   = 10'b0000100000,
    S_K    = 10'b0001000000,
    S_NUM  = 10'b0010000000,
    S_DUTY = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [11:0] lambda_heat, lambda_cool, alpha;
  logic [15:0] switch_gain, boundary_layer;
  logic [3:0]  cool_gain_factor;
  logic [14:0] duty_limit;

  logic               seen       [NUM_CHANNELS];
  logic [31:0]        prev_time  [NUM_CHANNELS];
  logic signed [16:0] prev_error [NUM_CHANNELS];
  logic [14:0]        prev_duty  [NUM_CHANNELS];

  logic [IDX_W-1:0]   idx;
  logic [1:0]         cur_chan;
  logic signed [16:0] e;
  logic               de_neg;
  logic [27:0]        ed_mag;
  logic               ed_neg;
  logic signed [47:0] s;
  logic [16:0]        sat_mag;
  logic               sat_neg;
  logic [MUL_P_W-1:0] pdp;
  logic signed [47:0] num;
  logic [14:0]        pd;
  logic [14:0]        res_duty;
  logic               res_first;

  logic        out_valid;
  logic [1:0]  out_chan;
  logic [14:0] out_duty;
  logic        out_first;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic               in_fire;
  logic               chan_ok;
  logic [IDX_W-1:0]   in_idx;
  logic [31:0]        raw_dt;
  logic [15:0]        dt;
  logic signed [16:0] e_in;
  logic [17:0]        de;
  logic [17:0]        de_mag;
  logic [27:0]        de_k;
  logic               e_neg;
  logic [11:0]        lam;
  logic [11:0]        a_eff;
  logic [15:0]        phi_eff;
  logic [3:0]         cgf_eff;
  logic [19:0]        k;
  logic [47:0]        prod_ext;
  logic signed [47:0] s_next;
  logic [47:0]        s_mag;
  logic               s_clamp;
  logic [47:0]        ed_s;
  logic [47:0]        k_s;
  logic signed [47:0] num_next;
  logic               num_pos;
  logic               num_big;
  logic               finish;
  logic [14:0]        fin_duty;
  logic [14:0]        quo_duty;
  logic               out_load;

  smhc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  smhc_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));

  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_fire       = samples.valid && samples.ready;
  assign chan_ok       = 32'(samples.chan) < NUM_CHANNELS;
  assign in_idx        = IDX_W'(samples.chan);

  assign raw_dt = samples.time_ms - prev_time[in_idx];
  assign dt     = (raw_dt == 32'd0 || raw_dt > 32'(MAX_STEP_MS)) ?
                  16'(DEFAULT_STEP_MS) : raw_dt[15:0];
  assign e_in   = {samples.setpoint_temp[15], samples.setpoint_temp}
                - {samples.measured_temp[15], samples.measured_temp};
  assign de     = {e_in[16], e_in} - {prev_error[in_idx][16], prev_error[in_idx]};
  assign de_mag = de[17] ? (18'd0 - de) : de;
  assign de_k   = (28'(de_mag) << 10) - (28'(de_mag) << 4) - (28'(de_mag) << 3);

  assign e_neg   = e[16];
  assign lam     = e_neg ? lambda_cool : lambda_heat;
  assign a_eff   = (alpha == 12'd0) ? 12'd1 : alpha;
  assign phi_eff = (boundary_layer == 16'd0) ? 16'd1 : boundary_layer;
  assign cgf_eff = (cool_gain_factor == 4'd0) ? 4'd1 : cool_gain_factor;
  assign k       = 20'(switch_gain) * 20'(e_neg ? cgf_eff : 4'd1);

  assign prod_ext = 48'(mul_rsp.prod);
  assign s_next   = {{23{e[16]}}, e, 8'd0} + (ed_neg ? (48'd0 - prod_ext) : prod_ext);
  assign s_mag    = s[47] ? (48'd0 - s) : s;
  assign s_clamp  = s_mag >= (48'(phi_eff) << 8);
  assign ed_s     = ed_neg ? (48'd0 - 48'(ed_mag)) : 48'(ed_mag);
  assign k_s      = sat_neg ? (48'd0 - prod_ext) : prod_ext;
  assign num_next = (ed_s << 16) + (48'(pdp) << 6) + k_s;
  assign num_pos  = !num[47] && (num != 48'sd0);
  assign num_big  = num >= (48'(a_eff) << 21);
  assign quo_duty = div_rsp.quo[14:0];

  always_comb begin
    state_next = state;
    div_req    = '0;
    mul_req    = '0;
    finish     = 1'b0;
    fin_duty   = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (chan_ok && seen[in_idx]) begin
            div_req.start = 1'b1;
            div_req.num   = 48'(de_k);
            div_req.den   = 48'(dt) << 27;
            div_req.bits  = CNT_W'(28);
            state_next    = S_ED;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ED: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = div_rsp.quo;
          mul_req.b     = MUL_B_W'(lam);
          state_next    = S_LAM;
        end
      end
      S_LAM: begin
        if (mul_rsp.done) begin
          state_next = S_SURF;
        end
      end
      S_SURF: begin
        if (s_clamp) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(pd);
          mul_req.b     = MUL_B_W'(a_eff);
          state_next    = S_PD;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = s_mag << 8;
          div_req.den   = 48'(phi_eff) << 15;
          div_req.bits  = CNT_W'(16);
          state_next    = S_SAT;
        end
      end
      S_SAT: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(pd);
          mul_req.b     = MUL_B_W'(a_eff);
          state_next    = S_PD;
        end
      end
      S_PD: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(k);
          mul_req.b     = sat_mag;
          state_next    = S_K;
        end
      end
      S_K: begin
        if (mul_rsp.done) begin
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        if (!num_pos) begin
          finish     = 1'b1;
          state_next = S_DONE;
        end else if (num_big) begin
          finish     = 1'b1;
          fin_duty   = duty_limit;
          state_next = S_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = num;
          div_req.den   = 48'(a_eff) << 20;
          div_req.bits  = CNT_W'(15);
          state_next    = S_DUTY;
        end
      end
      S_DUTY: begin
        if (div_rsp.done) begin
          finish     = 1'b1;
          fin_duty   = (quo_duty > duty_limit) ? duty_limit : quo_duty;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_load = (state == S_DONE) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      lambda_heat      <= 12'd384;
      lambda_cool      <= 12'd0;
      alpha            <= 12'd512;
      switch_gain      <= 16'd128;
      cool_gain_factor <= 4'd4;
      boundary_layer   <= 16'd960;
      duty_limit       <= 15'd25600;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        seen[i]       <= 1'b0;
        prev_time[i]  <= '0;
        prev_error[i] <= '0;
        prev_duty[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_LAMBDA_HEAT: lambda_heat      <= cfg.data[11:0];
          REG_LAMBDA_COOL: lambda_cool      <= cfg.data[11:0];
          REG_ALPHA:       alpha            <= cfg.data[11:0];
          REG_SWITCH_GAIN: switch_gain      <= cfg.data;
          REG_COOL_FACTOR: cool_gain_factor <= cfg.data[3:0];
          REG_BOUNDARY:    boundary_layer   <= cfg.data;
          REG_DUTY_LIMIT:  duty_limit       <= cfg.data[14:0];
          default: ;
        endcase
      end
      if (in_fire && chan_ok) begin
        seen[in_idx]      <= 1'b1;
        prev_time[in_idx] <= samples.time_ms;
      end
      if (finish) begin
        prev_duty[idx]  <= fin_duty;
        prev_error[idx] <= e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_chan  <= samples.chan;
      idx       <= in_idx;
      e         <= e_in;
      de_neg    <= de[17];
      pd        <= prev_duty[in_idx];
      res_first <= chan_ok && !seen[in_idx];
      res_duty  <= '0;
    end
    if (state == S_ED && div_rsp.done) begin
      ed_mag <= div_rsp.quo;
      ed_neg <= de_neg;
    end
    if (state == S_LAM && mul_rsp.done) begin
      s <= s_next;
    end
    if (state == S_SURF) begin
      sat_neg <= s[47];
      if (s_clamp) begin
        sat_mag <= 17'h10000;
      end
    end
    if (state == S_SAT && div_rsp.done) begin
      sat_mag <= div_rsp.quo[16:0];
    end
    if (state == S_PD && mul_rsp.done) begin
      pdp <= mul_rsp.prod;
    end
    if (state == S_K && mul_rsp.done) begin
      num <= num_next;
    end
    if (finish) begin
      res_duty <= fin_duty;
    end
    if (out_load) begin
      out_chan  <= cur_chan;
      out_duty  <= res_duty;
      out_first <= res_first;
    end
  end

  assign results.valid        = out_valid;
  assign results.out_chan     = out_chan;
  assign results.duty         = out_duty;
  assign results.first_sample = out_first;

  `SMHC_NEVER(a_div_restart, div_req.start && div_rsp.busy, "divider started while busy")
  `SMHC_NEVER(a_mul_restart, mul_req.start && mul_rsp.busy, "multiplier started while busy")
  `SMHC_ASSERT(a_leave_idle, in_fire |=> state != S_IDLE, "sequencer stayed idle after transfer")
  `SMHC_ASSERT(a_first_zero, results.valid && results.first_sample |-> results.duty == 15'd0, "first sample with nonzero duty")

endmodule
